/* rtl/rhbp_pkg.sv */
// Shared types, field codes and the header layout table for the replay header parser.
package rhbp_pkg;

    // Header layout
    localparam int unsigned NUM_FIELDS = 20;
    localparam int unsigned CODE_W     = 5;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned SKIP_W     = 32;

    // Field codes that the walker treats specially
    localparam logic [CODE_W-1:0] FLD_MAP_HASH    = 5'd2;
    localparam logic [CODE_W-1:0] FLD_PLAYER      = 5'd3;
    localparam logic [CODE_W-1:0] FLD_REPLAY_HASH = 5'd4;
    localparam logic [CODE_W-1:0] FLD_MODS        = 5'd14;
    localparam logic [CODE_W-1:0] FLD_LIFE_BAR    = 5'd15;
    localparam logic [CODE_W-1:0] FLD_PAYLOAD_LEN = 5'd17;
    localparam logic [CODE_W-1:0] FLD_RECORD_ID   = 5'd18;
    localparam logic [CODE_W-1:0] FLD_EXTRA       = 5'd19;
    localparam logic [CODE_W-1:0] FLD_LAST_CODE   = 5'd19;

    // String marker bytes and the mods value that adds the extra field
    localparam logic [7:0]        MARK_EMPTY   = 8'h00;
    localparam logic [7:0]        MARK_PRESENT = 8'h0B;
    localparam logic [SKIP_W-1:0] EXTRA_MODS   = 32'h0080_0000;

    // ULEB128 shift handling
    localparam logic [5:0] LEB_STEP = 6'd7;
    localparam logic [5:0] LEB_SAT  = 6'd35;
    localparam logic [5:0] LEB_KEEP = 6'd32;

    // Progress through a string field
    typedef enum logic [1:0] {
        PH_MARKER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_SKIP   = 2'd2
    } str_phase_t;

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic [CODE_W-1:0]  field_code;
        logic [VALUE_W-1:0] field_value;
        logic               bad_marker;
        logic               header_done;
    } result_t;

    // Width of each field in bytes; zero marks a string field.
    function automatic logic [3:0] field_width(input logic [CODE_W-1:0] code);
        logic [3:0] w;
        unique case (code)
            5'd0, 5'd13:                               w = 4'd1;
            5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd12: w = 4'd2;
            5'd1, 5'd11, 5'd14, 5'd17:                 w = 4'd4;
            5'd16, 5'd18, 5'd19:                       w = 4'd8;
            default:                                   w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/rhbp_in_stage.sv */
// Input register that holds one byte word until the field walker takes it.
module rhbp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rhbp_pkg::in_word_t s_word,
    output logic              word_valid,
    output rhbp_pkg::in_word_t word,
    input  logic              word_take
);
    import rhbp_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    // Room for a new word when empty or when the held word leaves this cycle.
    assign s_tready   = !valid_reg || word_take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            word_reg <= s_word;
        end
    end

endmodule

/* rtl/rhbp_field_walker.sv */
// Header state walker: consumes one byte per step and produces at most one field result.
module rhbp_field_walker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  rhbp_pkg::in_word_t word,
    output logic               res_valid,
    output rhbp_pkg::result_t  res
);
    import rhbp_pkg::*;

    logic [CODE_W-1:0]  field_index_reg, field_index_next;
    logic [2:0]         byte_index_reg, byte_index_next;
    str_phase_t         phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [5:0]         leb_shift_reg, leb_shift_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [SKIP_W-1:0]  mods_reg, mods_next;
    logic               finished_reg, finished_next;

    // State as seen by this byte, after a restart if one is flagged
    logic [CODE_W-1:0]  cur_field;
    logic [2:0]         cur_byte;
    str_phase_t         cur_phase;
    logic [VALUE_W-1:0] cur_acc;
    logic [5:0]         cur_leb;
    logic [SKIP_W-1:0]  cur_skip;
    logic [SKIP_W-1:0]  cur_mods;
    logic               cur_finished;

    logic [7:0]         b;
    logic [3:0]         width;
    logic [VALUE_W-1:0] int_acc;
    logic [SKIP_W-1:0]  leb_bits;
    logic [SKIP_W-1:0]  leb_acc;
    logic [6:0]         leb_sum;
    logic               emit;
    logic [VALUE_W-1:0] value;
    logic               bad;
    logic               done;

    assign b = word.data_byte;

    // Restart clears the state before the byte is parsed.
    always_comb begin
        if (word.start_of_file) begin
            cur_field    = '0;
            cur_byte     = '0;
            cur_phase    = PH_MARKER;
            cur_acc      = '0;
            cur_leb      = '0;
            cur_skip     = '0;
            cur_mods     = '0;
            cur_finished = 1'b0;
        end else begin
            cur_field    = field_index_reg;
            cur_byte     = byte_index_reg;
            cur_phase    = phase_reg;
            cur_acc      = acc_reg;
            cur_leb      = leb_shift_reg;
            cur_skip     = skip_reg;
            cur_mods     = mods_reg;
            cur_finished = finished_reg;
        end
    end

    // Byte placement and ULEB128 accumulation
    assign width    = field_width(cur_field);
    assign int_acc  = cur_acc | ({56'd0, b} << {cur_byte, 3'b000});
    assign leb_bits = {25'd0, b[6:0]} << cur_leb[4:0];
    assign leb_acc  = (cur_leb < LEB_KEEP) ? (cur_acc[SKIP_W-1:0] | leb_bits)
                                           : cur_acc[SKIP_W-1:0];
    assign leb_sum  = {1'b0, cur_leb} + {1'b0, LEB_STEP};

    // Next state and result
    always_comb begin
        field_index_next = cur_field;
        byte_index_next  = cur_byte;
        phase_next       = cur_phase;
        acc_next         = cur_acc;
        leb_shift_next   = cur_leb;
        skip_next        = cur_skip;
        mods_next        = cur_mods;
        finished_next    = cur_finished;
        emit             = 1'b0;
        value            = '0;
        bad              = 1'b0;
        done             = 1'b0;

        if (!cur_finished && cur_field < FLD_LAST_CODE + 5'd1) begin
            if (width == 4'd0) begin
                // String field
                case (cur_phase)
                    PH_MARKER: begin
                        if (b == MARK_PRESENT) begin
                            phase_next     = PH_LENGTH;
                            acc_next       = '0;
                            leb_shift_next = '0;
                        end else begin
                            emit = 1'b1;
                            bad  = (b != MARK_EMPTY);
                        end
                    end
                    PH_LENGTH: begin
                        acc_next       = {32'd0, leb_acc};
                        leb_shift_next = (leb_sum > {1'b0, LEB_SAT}) ? LEB_SAT : leb_sum[5:0];
                        if (!b[7]) begin
                            if (leb_acc != '0) begin
                                phase_next = PH_SKIP;
                                skip_next  = leb_acc;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (cur_skip > 32'd1) begin
                            skip_next = cur_skip - 32'd1;
                        end else begin
                            skip_next = '0;
                            emit      = 1'b1;
                            value     = cur_acc;
                        end
                    end
                endcase
            end else if (cur_skip != '0) begin
                // Compressed payload bytes
                skip_next = cur_skip - 32'd1;
            end else begin
                // Little-endian integer field
                acc_next = int_acc;
                if ({1'b0, cur_byte} + 4'd1 < width) begin
                    byte_index_next = cur_byte + 3'd1;
                end else begin
                    emit  = 1'b1;
                    value = int_acc;
                    if (cur_field == FLD_MODS) begin
                        mods_next = int_acc[SKIP_W-1:0];
                    end else if (cur_field == FLD_PAYLOAD_LEN) begin
                        skip_next = int_acc[SKIP_W-1:0];
                    end else if (cur_field == FLD_RECORD_ID) begin
                        done = (cur_mods != EXTRA_MODS);
                    end else if (cur_field == FLD_EXTRA) begin
                        done = 1'b1;
                    end
                end
            end

            // A completed field moves on to the next one.
            if (emit) begin
                field_index_next = cur_field + 5'd1;
                byte_index_next  = '0;
                phase_next       = PH_MARKER;
                acc_next         = '0;
                leb_shift_next   = '0;
                finished_next    = done;
            end
        end
    end

    assign res_valid       = emit;
    assign res.field_code  = cur_field;
    assign res.field_value = value;
    assign res.bad_marker  = bad;
    assign res.header_done = done;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg <= '0;
            byte_index_reg  <= '0;
            phase_reg       <= PH_MARKER;
            acc_reg         <= '0;
            leb_shift_reg   <= '0;
            skip_reg        <= '0;
            mods_reg        <= '0;
            finished_reg    <= 1'b0;
        end else if (step) begin
            field_index_reg <= field_index_next;
            byte_index_reg  <= byte_index_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            leb_shift_reg   <= leb_shift_next;
            skip_reg        <= skip_next;
            mods_reg        <= mods_next;
            finished_reg    <= finished_next;
        end
    end

endmodule

/* rtl/rhbp_out_stage.sv */
// Result register that holds one field word until the master side takes it.
module rhbp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rhbp_pkg::result_t res,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rhbp_pkg::result_t m_word
);
    import rhbp_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    // Free when empty or when the held word is taken this cycle.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_word   = word_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= res;
        end
    end

endmodule

/* rtl/replay_header_byte_parser.sv */
// Top level of the replay header byte parser.
//
// The parser accepts one file byte per cycle for as long as the master side keeps m_tready high:
// each byte passes from an input register through the header state walker into a result
// register: the byte that completes a field waits in the input register and its field word
// then in the result register. While a result word waits for m_tready, the input stalls. Bytes
// that complete no field (inner integer bytes, string and payload bytes) produce no output word.
// Setting s_tuser on a byte restarts the walk at the mode field with that byte; after the final
// header field (tlast high) further bytes are dropped until a restart.
module replay_header_byte_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [4:0] field_code, [68:5] field_value, [71:69] zero
    output logic [0:0]  m_tuser,   // [0] bad_marker
    output logic        m_tlast    // header_done
);
    import rhbp_pkg::*;

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     step;
    logic     res_valid;
    result_t  res;
    logic     out_free;
    result_t  m_word;

    assign s_word.data_byte     = s_tdata;
    assign s_word.start_of_file = s_tuser[0];

    // A held word advances whenever the result register can accept it.
    assign step = word_valid && out_free;

    rhbp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_word),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (step)
    );

    rhbp_field_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    rhbp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_word   (m_word)
    );

    // Pack the result word onto the master side.
    assign m_tdata = {3'b000, m_word.field_value, m_word.field_code};
    assign m_tuser = m_word.bad_marker;
    assign m_tlast = m_word.header_done;

endmodule

/* rtl/rhbp_checker.sv */
// Port-level checks for the replay header parser, bound to the top level.
module rhbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import rhbp_pkg::*;

    logic [CODE_W-1:0] code;
    assign code = m_tdata[CODE_W-1:0];

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Only the record id or the extra field can close the header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> code == FLD_RECORD_ID || code == FLD_EXTRA)
        else $error("header end flagged on a non-final field");

    // The extra field always closes the header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && code == FLD_EXTRA |-> m_tlast)
        else $error("extra field without header end");

    // A bad marker can only come from a string field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> code == FLD_MAP_HASH || code == FLD_PLAYER ||
                                   code == FLD_REPLAY_HASH || code == FLD_LIFE_BAR)
        else $error("bad marker on an integer field");

endmodule

bind replay_header_byte_parser rhbp_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* test/tb_replay_header_byte_parser.sv */
// Self-checking testbench for the replay header byte parser with a field word predictor.
`timescale 1ns / 1ps

module tb_replay_header_byte_parser;
    import rhbp_pkg::*;

    localparam int unsigned PIPE_CYCLES = 2;
    localparam int unsigned SETTLE_CYCLES = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] start_of_file
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [4:0] field_code, [68:5] field_value, [71:69] zero
    logic [0:0]  m_tuser;   // [0] bad_marker
    logic        m_tlast;   // header_done

    // Predicted field words, oldest first.
    result_t expected_fields[$];
    // File bytes waiting to be sent: [8] start_of_file, [7:0] data_byte.
    logic [8:0] file_q[$];

    int  mismatch_count = 0;
    int  walked_count = 0;
    bit  quiet = 0;

    // Predictor copy of the header walker state.
    logic [4:0]  hp_field;
    logic [2:0]  hp_byte;
    str_phase_t  hp_phase;
    logic [63:0] hp_acc;
    logic [5:0]  hp_shift;
    logic [31:0] hp_skip;
    logic [31:0] hp_mods;
    logic        hp_finished;

    replay_header_byte_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #4_000_000;
        $display("replay_header_byte_parser: mismatch");
        $finish;
    end

    // Byte width of each header field; zero marks a string.
    function automatic int unsigned field_bytes(input logic [4:0] code);
        case (code)
            5'd0, 5'd13:                                 return 1;
            5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd12:  return 2;
            5'd1, 5'd11, 5'd14, 5'd17:                   return 4;
            5'd16, 5'd18, 5'd19:                         return 8;
            default:                                     return 0;
        endcase
    endfunction

    task automatic clear_walker();
        hp_field    = '0;
        hp_byte     = '0;
        hp_phase    = PH_MARKER;
        hp_acc      = '0;
        hp_shift    = '0;
        hp_skip     = '0;
        hp_mods     = '0;
        hp_finished = 1'b0;
    endtask

    // Append one byte to the end of the file being built.
    task automatic add_file_byte(input logic [8:0] v);
        file_q.insert(file_q.size(), v);
    endtask

    // Advance the predicted walker by one byte and report any completed field.
    task automatic walk_header_byte(input logic [7:0] b, input logic sof,
                                    output bit got, output result_t r, output bit walked);
        int unsigned w;
        logic [63:0] val;
        logic [63:0] leb_part;
        bit          bad;
        bit          done;
        got    = 0;
        walked = 0;
        r      = '0;
        val    = '0;
        bad    = 0;
        done   = 0;
        if (sof)
            clear_walker();
        if (hp_finished || hp_field >= NUM_FIELDS)
            return;
        walked = 1;
        w = field_bytes(hp_field);
        if (w == 0) begin
            if (hp_phase == PH_MARKER) begin
                if (b == MARK_PRESENT) begin
                    hp_phase = PH_LENGTH;
                    hp_acc   = '0;
                    hp_shift = '0;
                    return;
                end
                bad = (b != MARK_EMPTY);
            end else if (hp_phase == PH_LENGTH) begin
                // Only the low 32 bits of the length are kept.
                if (hp_shift < 6'd32) begin
                    leb_part = 64'(b[6:0]) << hp_shift;
                    hp_acc   = hp_acc | {32'h0, leb_part[31:0]};
                end
                hp_shift = (hp_shift + 6'd7 > 6'd35) ? 6'd35 : hp_shift + 6'd7;
                if (b[7])
                    return;
                if (hp_acc != 0) begin
                    hp_phase = PH_SKIP;
                    hp_skip  = hp_acc[31:0];
                    return;
                end
            end else begin
                if (hp_skip > 1) begin
                    hp_skip = hp_skip - 32'd1;
                    return;
                end
                hp_skip = '0;
                val     = hp_acc;
            end
        end else begin
            // Payload bytes ahead of the record id are dropped.
            if (hp_skip != 0) begin
                hp_skip = hp_skip - 32'd1;
                return;
            end
            hp_acc = hp_acc | (64'(b) << (8 * hp_byte));
            if (hp_byte + 1 < w) begin
                hp_byte = hp_byte + 3'd1;
                return;
            end
            val = hp_acc;
            if (hp_field == FLD_MODS)
                hp_mods = val[31:0];
            else if (hp_field == FLD_PAYLOAD_LEN)
                hp_skip = val[31:0];
            else if (hp_field == FLD_RECORD_ID)
                done = (hp_mods != EXTRA_MODS);
            else if (hp_field == FLD_EXTRA)
                done = 1;
        end
        got           = 1;
        r.field_code  = hp_field;
        r.field_value = val;
        r.bad_marker  = bad;
        r.header_done = done;
        hp_field = hp_field + 5'd1;
        hp_byte  = '0;
        hp_phase = PH_MARKER;
        hp_acc   = '0;
        hp_shift = '0;
        if (done)
            hp_finished = 1'b1;
    endtask

    // Send one word, with an optional idle burst ahead of it, and predict its outcome.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        bit      got;
        bit      walked;
        result_t r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        walk_header_byte(b, sof, got, r, walked);
        if (got)
            expected_fields.insert(expected_fields.size(), r);
        if (walked)
            walked_count++;
    endtask

    task automatic send_file_q();
        foreach (file_q[i])
            send_byte(file_q[i][7:0], file_q[i][8]);
        file_q.delete();
    endtask

    // Random value of n bytes that often lands on all zeros or all ones.
    function automatic logic [63:0] rand_value(input int n);
        logic [63:0] mask;
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            default: return {$urandom, $urandom} & mask;
        endcase
    endfunction

    task automatic push_int(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            add_file_byte({1'b0, v[8*i +: 8]});
    endtask

    task automatic push_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            add_file_byte({1'b0, 8'($urandom)});
    endtask

    // One string field in one of its encodings.
    task automatic push_string();
        int         len;
        logic [7:0] m;
        case ($urandom_range(0, 9))
            3: begin
                // Marker that is neither empty nor present.
                m = 8'($urandom);
                if (m == MARK_EMPTY || m == MARK_PRESENT)
                    m = m ^ 8'h80;
                add_file_byte({1'b0, m});
            end
            4, 5, 6: begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 300)
                                                  : $urandom_range(1, 12);
                add_file_byte({1'b0, MARK_PRESENT});
                if (len < 128) begin
                    add_file_byte({1'b0, 8'(len)});
                end else begin
                    add_file_byte({1'b0, 8'h80 | 8'(len & 'h7f)});
                    add_file_byte({1'b0, 8'(len >> 7)});
                end
                push_random_bytes(len);
            end
            7: begin
                // Lengths that decode to zero, including one that wraps at bit 32.
                add_file_byte({1'b0, MARK_PRESENT});
                case ($urandom_range(0, 2))
                    0: add_file_byte({1'b0, 8'h00});
                    1: begin
                        add_file_byte({1'b0, 8'h80});
                        add_file_byte({1'b0, 8'h00});
                    end
                    default: begin
                        repeat (4) add_file_byte({1'b0, 8'h80});
                        add_file_byte({1'b0, 8'($urandom) & 8'h70});
                    end
                endcase
            end
            8: begin
                // Long length whose upper bits are dropped; the shift saturates.
                len = $urandom_range(1, 6);
                add_file_byte({1'b0, MARK_PRESENT});
                add_file_byte({1'b0, 8'h80 | 8'(len)});
                repeat (3) add_file_byte({1'b0, 8'h80});
                add_file_byte({1'b0, 8'h80 | (8'($urandom) & 8'h70)});
                repeat ($urandom_range(0, 3)) add_file_byte({1'b0, 8'h80 | 8'($urandom)});
                add_file_byte({1'b0, 8'($urandom) & 8'h7f});
                push_random_bytes(len);
            end
            default: add_file_byte({1'b0, MARK_EMPTY});
        endcase
    endtask

    // A complete header with random content, possibly bad string markers, and a few trailing bytes.
    task automatic build_file();
        logic [31:0] mods;
        int          len;
        file_q.delete();
        push_int(rand_value(1), 1);
        file_q[0][8] = 1'b1;
        push_int(rand_value(4), 4);
        repeat (3) push_string();
        repeat (6) push_int(rand_value(2), 2);
        push_int(rand_value(4), 4);
        push_int(rand_value(2), 2);
        push_int(rand_value(1), 1);
        case ($urandom_range(0, 5))
            0, 1:    mods = EXTRA_MODS;
            2:       mods = EXTRA_MODS ^ (32'd1 << $urandom_range(0, 31));
            default: mods = 32'(rand_value(4));
        endcase
        push_int(64'(mods), 4);
        push_string();
        push_int(rand_value(8), 8);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        push_int(64'(len), 4);
        push_random_bytes(len);
        push_int(rand_value(8), 8);
        if (mods == EXTRA_MODS)
            push_int(rand_value(8), 8);
        push_random_bytes($urandom_range(0, 3));
    endtask

    // Hold the input until every predicted word has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES + 2) @(posedge aclk);
    endtask

    // Mode at zero and version at all ones.
    task automatic test_integer_extremes();
        send_byte(8'h00, 1'b1);
        repeat (4) send_byte(8'hFF, 1'b0);
    endtask

    // Zero length, a bad marker and a long saturating length with skipped marker-like bytes.
    task automatic test_string_markers();
        send_byte(MARK_PRESENT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(MARK_PRESENT, 1'b0);
        send_byte(8'h82, 1'b0);
        repeat (3) send_byte(8'h80, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(MARK_PRESENT, 1'b0);
        send_byte(MARK_EMPTY, 1'b0);
    endtask

    // Restart in the middle of a counter field, then a version with only the top bit set.
    task automatic test_restart();
        send_byte(8'h34, 1'b0);
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Mostly well-formed files, with truncated files and noise mixed in.
    task automatic test_random_files(input int n);
        int target;
        int cut;
        target = walked_count + n;
        while (walked_count < target) begin
            case ($urandom_range(0, 9))
                8: begin
                    build_file();
                    cut = $urandom_range(1, file_q.size() - 1);
                    while (file_q.size() > cut) void'(file_q.pop_back());
                end
                9: begin
                    file_q.delete();
                    repeat ($urandom_range(1, 20))
                        add_file_byte({($urandom_range(0, 15) == 0), 8'($urandom)});
                end
                default: build_file();
            endcase
            send_file_q();
        end
    endtask

    // Stimulus sequence.
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        clear_walker();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_integer_extremes();
        test_string_markers();
        test_restart();
        wait_for_results();
        test_random_files(650);
        wait_for_results();
        test_random_files(650);
        quiet = 1;
        test_random_files(150);

        s_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("replay_header_byte_parser: match");
        else
            $display("replay_header_byte_parser: mismatch");
        $finish;
    end

    // Result-side back-pressure in random bursts.
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_fields.size() == 0) begin
                $error("unexpected word: field_code %0d field_value %0h",
                       m_tdata[4:0], m_tdata[68:5]);
                mismatch_count++;
            end else begin
                want = expected_fields.pop_front();
                if (m_tdata[4:0] != want.field_code) begin
                    $error("field_code: expected %0d, actual %0d", want.field_code, m_tdata[4:0]);
                    mismatch_count++;
                end
                if (m_tdata[68:5] != want.field_value) begin
                    $error("field_value: expected %0h, actual %0h",
                           want.field_value, m_tdata[68:5]);
                    mismatch_count++;
                end
                if (m_tuser[0] != want.bad_marker) begin
                    $error("bad_marker: expected %0d, actual %0d", want.bad_marker, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tlast != want.header_done) begin
                    $error("header_done: expected %0d, actual %0d", want.header_done, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

/* sim.f */
rtl/rhbp_pkg.sv
rtl/rhbp_in_stage.sv
rtl/rhbp_field_walker.sv
rtl/rhbp_out_stage.sv
rtl/replay_header_byte_parser.sv
rtl/rhbp_checker.sv
test/tb_replay_header_byte_parser.sv
